>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; bodies compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PEE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PEE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/pee_pkg.sv
// shared types, constants and helpers of the postfix evaluator
// no dependencies
`timescale 1ns / 1ps
package pee_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ACC_W       = 15;
    localparam int DIVD_W      = 48;
    localparam int DIVS_W      = 32;
    localparam int DCNT_W      = $clog2(DIVD_W);

    localparam logic [ACC_W-1:0] ACC_MAX = 15'd32767;

    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW
    } t_op;

    typedef struct packed {
        logic capture;
        logic acc_upd;
        logic flag_under;
        logic rd_en;
        logic rd_second;
        logic lat_rhs;
        logic lat_lhs;
        logic addsub;
        logic mul_load;
        logic mul_sat;
        logic pow_init;
        logic div_start;
        logic div_zero;
        logic div_end;
        logic push_res;
        logic push_pend;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_space;
        t_op  op;
        logic last;
        logic cnt_lt2;
        logic rhs_zero;
        logic res_zero;
        logic pow_left;
        logic pow_neg;
        logic div_busy;
    } t_dp_status;

    function automatic t_op decode_op(input logic [7:0] c);
        t_op r;
        case (c)
            CH_PLUS:  r = OP_ADD;
            CH_MINUS: r = OP_SUB;
            CH_STAR:  r = OP_MUL;
            CH_SLASH: r = OP_DIV;
            CH_CARET: r = OP_POW;
            default:  r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction
endpackage

>>> hdl/pee_divider.sv
// restoring divider, one quotient bit per cycle
// depends on pee_pkg
`timescale 1ns / 1ps
module pee_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pee_pkg::DIVD_W-1:0] i_dividend,
    input  logic [pee_pkg::DIVS_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [pee_pkg::DIVD_W-1:0] o_quot
);
    logic [pee_pkg::DIVD_W-1:0] r_quot;
    logic [pee_pkg::DIVS_W-1:0] r_rem;
    logic [pee_pkg::DIVS_W-1:0] r_div;
    logic [pee_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic [pee_pkg::DIVS_W:0]   w_sh;
    logic [pee_pkg::DIVS_W+1:0] w_diff;
    logic                       w_ge;

    assign w_sh   = {r_rem, r_quot[pee_pkg::DIVD_W-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_div};
    assign w_ge   = ~w_diff[pee_pkg::DIVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pee_pkg::DCNT_W'(pee_pkg::DIVD_W - 1);
            r_quot <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[pee_pkg::DIVD_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[pee_pkg::DIVS_W-1:0] : w_sh[pee_pkg::DIVS_W-1:0];
            r_cnt  <= r_cnt - pee_pkg::DCNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

>>> hdl/pee_datapath.sv
// datapath: operand stack memory, number builder, q16.16 arithmetic and result register
// depends on pee_pkg and pee_divider
`timescale 1ns / 1ps
module pee_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_char,
    input  logic                 i_last,
    input  pee_pkg::t_dp_cmd     i_cmd,
    output pee_pkg::t_dp_status  o_status,
    output logic [31:0]          o_value,
    output logic [2:0]           o_code
);
    logic [31:0]                 mem [pee_pkg::STACK_DEPTH];
    logic [31:0]                 r_rdata;
    logic [7:0]                  r_char;
    logic                        r_last;
    logic [pee_pkg::CNT_W-1:0]   r_count;
    logic [pee_pkg::ACC_W-1:0]   r_acc;
    logic                        r_pending;
    logic [2:0]                  r_err;
    logic [31:0]                 r_rhs;
    logic [31:0]                 r_lhs;
    logic [31:0]                 r_res;
    logic signed [63:0]          r_prod;
    logic [5:0]                  r_pow_cnt;
    logic                        r_pow_neg;
    logic                        r_div_neg;
    logic [31:0]                 r_out_value;
    logic [2:0]                  r_out_code;

    logic [2:0]                  n_err;
    pee_pkg::t_op                w_op;
    logic                        w_full;
    logic [pee_pkg::CNT_W-1:0]   w_cm1;
    logic [pee_pkg::CNT_W-1:0]   w_cm2;
    logic [pee_pkg::ADDR_W-1:0]  w_raddr;
    logic                        w_we;
    logic [31:0]                 w_wdata;
    logic [18:0]                 w_acc_next;
    logic [32:0]                 w_sum;
    logic [47:0]                 w_q;
    logic                        w_mul_ovf;
    logic [15:0]                 w_ip;
    logic                        w_ip_neg;
    logic [5:0]                  w_pow_mag;
    logic [pee_pkg::DIVD_W-1:0]  w_dividend;
    logic [pee_pkg::DIVS_W-1:0]  w_divisor;
    logic                        w_dneg;
    logic                        w_div_busy;
    logic [pee_pkg::DIVD_W-1:0]  w_quot;
    logic                        w_div_ovf;
    logic [31:0]                 w_div_val;
    logic                        w_raise;
    logic [2:0]                  w_code;

    assign w_op  = pee_pkg::decode_op(r_char);
    assign w_full = (r_count == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH));
    assign w_cm1 = r_count - pee_pkg::CNT_W'(1);
    assign w_cm2 = r_count - pee_pkg::CNT_W'(2);
    assign w_raddr = i_cmd.rd_second ? w_cm2[pee_pkg::ADDR_W-1:0]
                                     : w_cm1[pee_pkg::ADDR_W-1:0];

    assign w_we = !w_full && (i_cmd.push_res || (i_cmd.push_pend && r_pending));
    assign w_wdata = i_cmd.push_res ? r_res : {1'b0, r_acc, 16'h0000};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_count[pee_pkg::ADDR_W-1:0]] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[w_raddr];
        end
    end

    assign w_acc_next = 19'(r_acc) * 19'd10 + 19'(r_char - pee_pkg::CH_ZERO);

    assign w_sum = (w_op == pee_pkg::OP_SUB) ? ({r_lhs[31], r_lhs} - {r_rhs[31], r_rhs})
                                             : ({r_lhs[31], r_lhs} + {r_rhs[31], r_rhs});

    assign w_q       = r_prod[63:16];
    assign w_mul_ovf = (w_q[47:31] != {17{w_q[31]}});

    // exponent: integer part truncated toward zero, clamped to 63 in magnitude
    always_comb begin
        w_ip = r_rhs[31:16];
        if (r_rhs[31] && (r_rhs[15:0] != 16'h0000)) begin
            w_ip = w_ip + 16'd1;
        end
        w_ip_neg = w_ip[15];
        if (w_ip_neg) begin
            w_pow_mag = ($signed(w_ip) < -16'sd63) ? 6'd63 : 6'(16'd0 - w_ip);
        end else begin
            w_pow_mag = ($signed(w_ip) > 16'sd63) ? 6'd63 : w_ip[5:0];
        end
    end

    always_comb begin
        if (w_op == pee_pkg::OP_POW) begin
            w_dividend = 48'h0001_0000_0000;
            w_divisor  = pee_pkg::abs32(r_res);
            w_dneg     = r_res[31];
        end else begin
            w_dividend = {pee_pkg::abs32(r_lhs), 16'h0000};
            w_divisor  = pee_pkg::abs32(r_rhs);
            w_dneg     = r_lhs[31] ^ r_rhs[31];
        end
    end

    pee_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    always_comb begin
        if (r_div_neg) begin
            w_div_ovf = (w_quot > 48'h0000_8000_0000);
            w_div_val = w_div_ovf ? pee_pkg::Q_MIN : (32'd0 - w_quot[31:0]);
        end else begin
            w_div_ovf = (w_quot > 48'h0000_7FFF_FFFF);
            w_div_val = w_div_ovf ? pee_pkg::Q_MAX : w_quot[31:0];
        end
    end

    always_comb begin
        w_raise = 1'b0;
        w_code  = pee_pkg::ST_OVER;
        if (i_cmd.flag_under) begin
            w_raise = 1'b1;
            w_code  = pee_pkg::ST_UNDER;
        end else if (i_cmd.div_zero) begin
            w_raise = 1'b1;
            w_code  = pee_pkg::ST_DIV0;
        end else if (i_cmd.addsub) begin
            w_raise = (w_sum[32] != w_sum[31]);
        end else if (i_cmd.mul_sat) begin
            w_raise = w_mul_ovf;
        end else if (i_cmd.div_end) begin
            w_raise = w_div_ovf;
        end else if (i_cmd.push_res || (i_cmd.push_pend && r_pending)) begin
            w_raise = w_full;
        end
        n_err = (w_raise && (r_err == pee_pkg::ST_OK)) ? w_code : r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_acc     <= '0;
            r_pending <= 1'b0;
            r_err     <= pee_pkg::ST_OK;
        end else if (i_cmd.emit) begin
            r_count   <= '0;
            r_acc     <= '0;
            r_pending <= 1'b0;
            r_err     <= pee_pkg::ST_OK;
        end else begin
            r_err <= n_err;
            if (i_cmd.acc_upd) begin
                r_acc     <= (w_acc_next > 19'(pee_pkg::ACC_MAX)) ? pee_pkg::ACC_MAX
                                                                  : w_acc_next[14:0];
                r_pending <= 1'b1;
            end
            if (i_cmd.push_pend) begin
                r_acc     <= '0;
                r_pending <= 1'b0;
            end
            if (i_cmd.lat_lhs) begin
                r_count <= w_cm2;
            end else if (w_we) begin
                r_count <= r_count + pee_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_char <= i_char;
            r_last <= i_last;
        end
        if (i_cmd.lat_rhs) begin
            r_rhs <= r_rdata;
        end
        if (i_cmd.lat_lhs) begin
            r_lhs <= r_rdata;
        end
        if (i_cmd.mul_load) begin
            r_prod <= $signed((w_op == pee_pkg::OP_POW) ? r_res : r_rhs) * $signed(r_lhs);
        end
        if (i_cmd.addsub) begin
            r_res <= (w_sum[32] != w_sum[31]) ? (w_sum[32] ? pee_pkg::Q_MIN : pee_pkg::Q_MAX)
                                             : w_sum[31:0];
        end else if (i_cmd.mul_sat) begin
            r_res <= w_mul_ovf ? (w_q[47] ? pee_pkg::Q_MIN : pee_pkg::Q_MAX) : w_q[31:0];
        end else if (i_cmd.pow_init) begin
            r_res <= pee_pkg::Q_ONE;
        end else if (i_cmd.div_zero) begin
            r_res <= '0;
        end else if (i_cmd.div_end) begin
            r_res <= w_div_val;
        end
        if (i_cmd.pow_init) begin
            r_pow_cnt <= w_pow_mag;
            r_pow_neg <= w_ip_neg;
        end else if (i_cmd.mul_sat && (w_op == pee_pkg::OP_POW)) begin
            r_pow_cnt <= r_pow_cnt - 6'd1;
        end
        if (i_cmd.div_start) begin
            r_div_neg <= w_dneg;
        end
        if (i_cmd.emit) begin
            r_out_value <= (r_count != '0) ? r_rdata : 32'd0;
            r_out_code  <= (r_err != pee_pkg::ST_OK) ? r_err
                         : ((r_count == '0) ? pee_pkg::ST_EMPTY : pee_pkg::ST_OK);
        end
    end

    assign o_status.is_digit = (r_char inside {[pee_pkg::CH_ZERO:pee_pkg::CH_NINE]});
    assign o_status.is_space = (r_char == pee_pkg::CH_SPACE);
    assign o_status.op       = w_op;
    assign o_status.last     = r_last;
    assign o_status.cnt_lt2  = (r_count < pee_pkg::CNT_W'(2));
    assign o_status.rhs_zero = (r_rhs == 32'd0);
    assign o_status.res_zero = (r_res == 32'd0);
    assign o_status.pow_left = (r_pow_cnt != 6'd0);
    assign o_status.pow_neg  = r_pow_neg;
    assign o_status.div_busy = w_div_busy;

    assign o_value = r_out_value;
    assign o_code  = r_out_code;
endmodule

>>> hdl/pee_ctrl.sv
// controller state machine: sequences each character through the datapath
// depends on pee_pkg
`timescale 1ns / 1ps
module pee_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  pee_pkg::t_dp_status i_status,
    output pee_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RD1, S_RD2, S_OP, S_MUL_S, S_POW_CHK,
        S_DIV_RUN, S_DIV_END, S_PUSH, S_PEND, S_TOP, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_status.last ? S_PEND : S_IDLE;
                if (i_status.is_digit) begin
                    o_cmd.acc_upd = 1'b1;
                end else if (i_status.is_space) begin
                    n_state = S_PEND;
                end else if (i_status.op != pee_pkg::OP_NONE) begin
                    if (i_status.cnt_lt2) begin
                        o_cmd.flag_under = 1'b1;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        n_state = S_RD1;
                    end
                end
            end
            S_RD1: begin
                o_cmd.lat_rhs   = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_second = 1'b1;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.lat_lhs = 1'b1;
                n_state = S_OP;
            end
            S_OP: begin
                case (i_status.op)
                    pee_pkg::OP_MUL: begin
                        o_cmd.mul_load = 1'b1;
                        n_state = S_MUL_S;
                    end
                    pee_pkg::OP_DIV: begin
                        if (i_status.rhs_zero) begin
                            o_cmd.div_zero = 1'b1;
                            n_state = S_PUSH;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV_RUN;
                        end
                    end
                    pee_pkg::OP_POW: begin
                        o_cmd.pow_init = 1'b1;
                        n_state = S_POW_CHK;
                    end
                    default: begin
                        o_cmd.addsub = 1'b1;
                        n_state = S_PUSH;
                    end
                endcase
            end
            S_MUL_S: begin
                o_cmd.mul_sat = 1'b1;
                n_state = (i_status.op == pee_pkg::OP_POW) ? S_POW_CHK : S_PUSH;
            end
            S_POW_CHK: begin
                if (i_status.pow_left) begin
                    o_cmd.mul_load = 1'b1;
                    n_state = S_MUL_S;
                end else if (!i_status.pow_neg) begin
                    n_state = S_PUSH;
                end else if (i_status.res_zero) begin
                    o_cmd.div_zero = 1'b1;
                    n_state = S_PUSH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV_RUN;
                end
            end
            S_DIV_RUN: begin
                if (!i_status.div_busy) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.div_end = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push_res = 1'b1;
                n_state = i_status.last ? S_PEND : S_IDLE;
            end
            S_PEND: begin
                o_cmd.push_pend = 1'b1;
                n_state = i_status.last ? S_TOP : S_IDLE;
            end
            S_TOP: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

>>> hdl/postfix_expression_evaluator_core.sv
// postfix expression evaluator, top level
// depends on pee_pkg, pee_ctrl, pee_datapath and assert_macros.svh
//
// usage: characters of a postfix expression arrive one per request on the
// s_axis channel (tdata = ascii code, tlast marks the final character).
// digits build a number, space pushes it, + - * / ^ work on the stack in
// signed q16.16. after the request with tlast the m_axis channel carries one
// result: tdata = top of stack, tuser = status (ok, underflow, overflow,
// divide by zero, empty stack).
// one character is handled at a time; codes other than digits, space and
// operators are ignored. / uses the 48-step divider, ^ repeats a multiply
// per exponent step and divides one by the result for a negative exponent.
// tlast then pushes any pending number and loads the top of stack as result.
// the result sits in an output register, so new characters are taken while
// it waits; only loading the next result waits for m_axis_tready.
// synchronous active-low reset empties the stack and drops any result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module postfix_expression_evaluator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    pee_pkg::t_dp_cmd    w_cmd;
    pee_pkg::t_dp_status w_status;

    pee_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    pee_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_value  (m_axis_tdata),
        .o_code   (m_axis_tuser)
    );

    `PEE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PEE_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, w_cmd.emit, m_axis_tvalid && (m_axis_tuser <= 3'd4))
    `PEE_ASSERT_NOW(a_one_mem_op, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.push_res, w_cmd.push_pend, w_cmd.rd_en}))
    `PEE_ASSERT_NOW(a_div_idle_start, i_clk, i_rst_n, w_cmd.div_start, !w_status.div_busy)
endmodule
